// ===== rtl/lcs_pkg.sv =====
// Shared sizes, command codes and the packet that moves along the LCS cell chain.
package lcs_pkg;

	localparam int MAX_REF_LEN = 64;
	localparam int SYMBOL_BITS = 8;
	localparam int SYM_W       = 8;
	localparam int LEN_W       = $clog2(MAX_REF_LEN + 1);

	typedef logic [SYMBOL_BITS-1:0] sym_t;
	typedef logic [LEN_W-1:0]       len_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
		sym_t sym;
		logic start;
		logic taken;
		len_t left;
		len_t diag;
	} pkt_t;

endpackage

// ===== rtl/lcs_cell.sv =====
// One DP cell: holds a reference symbol and its row length, updates as packets pass.
module lcs_cell import lcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  pkt_t pkt_in,
	output pkt_t pkt_out
);

	sym_t ref_sym_q;
	logic ref_valid_q;
	len_t row_q;
	pkt_t pkt_q;

	pkt_t pkt_nxt;
	sym_t ref_sym_nxt;
	logic ref_valid_nxt;
	len_t row_nxt;
	len_t up;
	len_t best;

	always_comb begin
		pkt_nxt       = pkt_in;
		ref_sym_nxt   = ref_sym_q;
		ref_valid_nxt = ref_valid_q;
		row_nxt       = row_q;
		up            = pkt_in.start ? '0 : row_q;
		best          = (up >= pkt_in.left) ? up : pkt_in.left;
		if (pkt_in.vld) begin
			unique case (pkt_in.cmd)
				CMD_LOAD: begin
					if (pkt_in.start || !ref_valid_q) begin
						if (!pkt_in.taken) begin
							// first free slot takes the symbol
							ref_sym_nxt   = pkt_in.sym;
							ref_valid_nxt = 1'b1;
							row_nxt       = '0;
							pkt_nxt.taken = 1'b1;
						end else if (pkt_in.start) begin
							ref_valid_nxt = 1'b0;
							row_nxt       = '0;
						end
					end
				end
				CMD_QUERY: begin
					pkt_nxt.diag = up;
					if (ref_valid_q) begin
						if (ref_sym_q == pkt_in.sym) begin
							row_nxt = pkt_in.diag + len_t'(1);
						end else begin
							row_nxt = best;
						end
						pkt_nxt.left = row_nxt;
					end else begin
						row_nxt = up;
					end
				end
				default: begin
					pkt_nxt = pkt_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_valid_q <= 1'b0;
			row_q       <= '0;
			pkt_q       <= '0;
		end else if (advance) begin
			ref_valid_q <= ref_valid_nxt;
			row_q       <= row_nxt;
			pkt_q       <= pkt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ref_sym_q <= ref_sym_nxt;
		end
	end

	assign pkt_out = pkt_q;

endmodule

// ===== rtl/lcs_length_engine.sv =====
// Top level: systolic chain computing LCS length of a streamed query against a stored reference.
//
// Usage:
//   Input channel (item_valid / item_stall) carries command, symbol and start_req.
//   A load transaction (command 0) appends one reference symbol; with start_req set
//   it begins a new reference. Symbols past MAX_REF_LEN (64) are dropped.
//   A query transaction (command 1) runs one DP row; start_req clears the row first.
//   Each query yields one result transaction (result_valid / result_stall) carrying
//   lcs_length; loads yield none.
// Path: a transaction walks through the MAX_REF_LEN cells in order, one cell register after
//   another, then through the result register, before result_valid rises.
// Throughput: one transaction per cycle unless stalled; loads and queries mix freely;
//   the skewed wavefront lets cell j work on query i while cell j+1 works on query i-1.
// Stall: the whole chain advances together. While a result waits under result_stall,
//   the chain freezes and item_stall is high; otherwise input is never stalled.
// Reset: arst_n clears the reference length (all cells empty), the row and all
//   packet valid bits. No clearing pass is needed.
module lcs_length_engine import lcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               command,
	input  logic [SYM_W-1:0]   symbol,
	input  logic               start_req,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [LEN_W-1:0]   lcs_length
);

	pkt_t chain [0:MAX_REF_LEN];
	logic advance;
	logic result_valid_q;
	len_t lcs_length_q;

	// chain moves unless a finished result is held by the receiver
	assign advance    = !(result_valid_q && result_stall);
	assign item_stall = !advance;

	// entry packet: zero-padded left border
	always_comb begin
		chain[0].vld   = item_valid;
		chain[0].cmd   = cmd_t'(command);
		chain[0].sym   = symbol[SYMBOL_BITS-1:0];
		chain[0].start = start_req;
		chain[0].taken = 1'b0;
		chain[0].left  = '0;
		chain[0].diag  = '0;
	end

	for (genvar j = 0; j < MAX_REF_LEN; j++) begin : g_cell
		lcs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.pkt_in  (chain[j]),
			.pkt_out (chain[j+1])
		);
	end

	// inactive cells pass left through, so the chain tail holds row[n-1] (or 0)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= chain[MAX_REF_LEN].vld && (chain[MAX_REF_LEN].cmd == CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lcs_length_q <= chain[MAX_REF_LEN].left;
		end
	end

	assign result_valid = result_valid_q;
	assign lcs_length   = lcs_length_q;

	// length can never exceed reference capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (lcs_length <= len_t'(MAX_REF_LEN)))
		else $error("lcs_length beyond reference capacity");

	// a new result only comes from a query leaving the chain tail
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |->
			$past(chain[MAX_REF_LEN].vld && (chain[MAX_REF_LEN].cmd == CMD_QUERY)))
		else $error("result without a query at chain tail");

	// a frozen chain keeps the valid bit of its tail packet
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(chain[MAX_REF_LEN].vld))
		else $error("chain tail moved while stalled");

endmodule
